[rtl/rpe_pkg.sv]
// Package for the rudder plant Euler step: constants, water torque table, helpers.
// No dependencies.
`timescale 1ns / 1ps
package rpe_pkg;

    localparam int TablePoints = 25;
    localparam int DataW       = 32;
    localparam int CfgW        = 32;
    localparam int CfgIdxW     = 3;

    localparam logic [CfgIdxW-1:0] CFG_SAMPLE_TIME   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_INERTIA       = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_LEVER_ARM     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_WATER_SPEED   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_WATER_HEADING = 3'd4;

    localparam logic [30:0] SampleTimeRst = 31'd6554;
    localparam logic [30:0] InertiaRst    = 31'd268042240;
    localparam logic signed [31:0] LeverArmRst = 32'sd201851;

    localparam logic signed [31:0] KDampSq  = 32'sd279511040;
    localparam logic signed [31:0] KDampLin = 32'sd865075;

    function automatic logic signed [31:0] torque_tab(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd0;
            5'd1:  v = -32'sd871629;
            5'd2:  v = -32'sd6488064;
            5'd3:  v = -32'sd9456845;
            5'd4:  v = -32'sd12301107;
            5'd5:  v = -32'sd7864320;
            5'd6:  v = -32'sd5328077;
            5'd7:  v = -32'sd2129920;
            5'd8:  v = 32'sd2215117;
            5'd9:  v = 32'sd1251738;
            5'd10: v = 32'sd583270;
            5'd11: v = -32'sd471859;
            5'd12: v = 32'sd0;
            5'd13: v = -32'sd471859;
            5'd14: v = 32'sd583270;
            5'd15: v = 32'sd1251738;
            5'd16: v = 32'sd2215117;
            5'd17: v = -32'sd2129920;
            5'd18: v = -32'sd5328077;
            5'd19: v = -32'sd7864320;
            5'd20: v = -32'sd12301107;
            5'd21: v = -32'sd9456845;
            5'd22: v = -32'sd6488064;
            5'd23: v = -32'sd871629;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/rpe_mul.sv]
// Bit-serial signed multiplier with a shifting operand register, optional rounded
// right shift by 16 and saturation to 32 bits. Depends on rpe_pkg.
`timescale 1ns / 1ps
module rpe_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic               i_shift,   // 1: divide by 2^16 rounded half away
    output logic               o_done,
    output logic signed [31:0] o_p,
    output logic               o_sat
);
    import rpe_pkg::*;

    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_mb, n_mb;        // magnitude of b, shifted right each cycle
    logic [63:0] r_ma, n_ma;        // magnitude of a, shifted left each cycle
    logic [63:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic signed [31:0] r_p, n_p;
    logic        r_sat, n_sat;

    logic [63:0] w_t;
    logic [48:0] w_q;

    always_comb begin
        n_busy = r_busy; n_cnt = r_cnt; n_mb = r_mb; n_ma = r_ma;
        n_acc = r_acc; n_neg = r_neg; n_done = 1'b0; n_p = r_p; n_sat = r_sat;
        w_t = i_shift ? (r_acc + 64'd32768) >> 16 : r_acc;
        w_q = (w_t[63:49] != '0) ? {49{1'b1}} : w_t[48:0];
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_ma   = {32'd0, i_a[31] ? 32'(-i_a) : 32'(i_a)};
            n_mb   = i_b[31] ? 32'(-i_b) : 32'(i_b);
            n_acc  = '0;
            n_neg  = i_a[31] ^ i_b[31];
        end else if (r_busy) begin
            if (r_mb[0]) n_acc = r_acc + r_ma;
            n_ma  = {r_ma[62:0], 1'b0};
            n_mb  = {1'b0, r_mb[31:1]};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd32) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_acc  = r_acc;
                // magnitude is below 2^64 with operands up to 2^31 each
                if (w_q > 49'h7FFFFFFF + {48'd0, r_neg}) begin
                    n_sat = 1'b1;
                    n_p   = r_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
                end else begin
                    n_sat = 1'b0;
                    n_p   = r_neg ? 32'(-w_q[31:0]) : 32'(w_q[31:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_mb <= n_mb; r_ma <= n_ma; r_acc <= n_acc; r_neg <= n_neg;
        r_p <= n_p; r_sat <= n_sat;
    end

    assign o_done = r_done;
    assign o_p    = r_p;
    assign o_sat  = r_sat;
endmodule

[rtl/rpe_div.sv]
// Restoring divider, one quotient bit per cycle, rounded half away from zero,
// saturated to 32 bits. Depends on rpe_pkg.
`timescale 1ns / 1ps
module rpe_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic [30:0]        i_den,
    output logic               o_done,
    output logic signed [31:0] o_q,
    output logic               o_sat
);
    import rpe_pkg::*;

    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [63:0] r_num;
    logic [31:0] r_den;
    logic [32:0] r_rem;
    logic [63:0] r_quo;
    logic        r_neg, r_done, r_sat;
    logic signed [31:0] r_q;

    logic [32:0] w_try;
    logic [63:0] w_rq;

    always_comb begin
        w_try = {r_rem[31:0], r_num[63]} - {1'b0, r_den};
        // round: add one when twice the remainder reaches the divisor
        w_rq  = r_quo + (({r_rem, 1'b0} >= {2'b0, r_den}) ? 64'd1 : 64'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1; r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd64) begin
                    r_busy <= 1'b0; r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_num <= i_num[63] ? 64'(-i_num) : 64'(i_num);
            r_den <= (i_den == '0) ? 32'd1 : {1'b0, i_den};
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= i_num[63];
        end else if (r_busy && r_cnt != 7'd64) begin
            r_num <= {r_num[62:0], 1'b0};
            if (!w_try[32]) begin
                r_rem <= w_try;
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_num[63]};
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end else if (r_busy) begin
            if (w_rq > 64'h7FFFFFFF + {63'd0, r_neg}) begin
                r_sat <= 1'b1;
                r_q   <= r_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
            end else begin
                r_sat <= 1'b0;
                r_q   <= r_neg ? 32'(-w_rq[31:0]) : 32'(w_rq[31:0]);
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_sat  = r_sat;
endmodule

[rtl/rudder_plant_euler_step.sv]
// Rudder plant Euler step: each input transfer runs one full step before the next
// input is taken. The step makes seven passes through the shared bit-serial
// multiplier, a serial angle-to-degree conversion, a serial division and seven
// one-state steps. The result is held in an output register; the next item is
// taken the cycle after the result has been transferred, so an output stall also
// holds off the next item. Write configuration only while no item is in flight.
// Depends on rpe_pkg, rpe_mul, rpe_div.
`timescale 1ns / 1ps
module rudder_plant_euler_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rpe_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [rpe_pkg::CfgW-1:0]          i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [rpe_pkg::DataW-1:0]  i_drive_force,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [rpe_pkg::DataW-1:0]  o_new_angle,
    output logic signed [rpe_pkg::DataW-1:0]  o_new_rate,
    output logic                              o_saturated
);
    import rpe_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_M_ANG, S_W_ANG, S_M_RR, S_W_RR, S_M_DSQ, S_W_DSQ, S_M_DLIN, S_W_DLIN,
        S_M_FL, S_W_FL, S_DEG, S_WREL, S_WIDX, S_WPROD, S_WSTEP, S_M_SQ, S_W_SQ,
        S_M_WV, S_W_WV, S_TRQ, S_D_START, S_D_WAIT, S_OUT
    } t_state;

    t_state r_state;
    logic [30:0] r_sample_time, r_inertia;
    logic signed [31:0] r_lever_arm, r_water_speed;
    logic signed [9:0] r_water_heading;
    logic signed [31:0] r_angle, r_rate;
    logic signed [31:0] r_force, r_new_angle, r_rr, r_dsq, r_fl, r_sq, r_wval, r_wt;
    logic signed [33:0] r_damp;
    logic signed [31:0] r_torque;
    logic r_sat, r_valid;
    logic signed [31:0] r_out_angle, r_out_rate;
    logic r_out_sat;
    // degree conversion: serial division of |angle|*18000 by 314*65536,
    // quotient kept only modulo 360
    logic [46:0] r_dnum;
    logic [24:0] r_drem;
    logic [8:0]  r_dmod;
    logic [5:0]  r_dcnt;
    // table interpolation stages
    logic [8:0]  r_rel;
    logic [4:0]  r_widx;
    logic [3:0]  r_woff;
    logic signed [31:0] r_wt0;
    logic        r_wneg;
    logic [27:0] r_wy;
    logic [23:0] r_wst;

    logic m_start, m_shift, m_done, m_sat;
    logic signed [31:0] m_a, m_b, m_p;
    logic d_start, d_done, d_sat;
    logic signed [31:0] d_q;
    logic signed [63:0] d_num;

    rpe_mul u_mul (.i_clk, .i_rst_n, .i_start(m_start), .i_a(m_a), .i_b(m_b),
                   .i_shift(m_shift), .o_done(m_done), .o_p(m_p), .o_sat(m_sat));
    rpe_div u_div (.i_clk, .i_rst_n, .i_start(d_start), .i_num(d_num),
                   .i_den(r_inertia), .o_done(d_done), .o_q(d_q), .o_sat(d_sat));

    localparam logic [24:0] DegDen = 25'd20578304; // 314 * 65536
    localparam logic [21:0] Recip15Idx = 22'd4370;      // ceil(2^16/15), rel < 360
    localparam logic [55:0] Recip15Step = 56'd143165577; // ceil(2^31/15)

    logic signed [11:0] w_hd, w_md, w_rel0;
    logic [8:0]  w_rel;
    logic [21:0] w_idxp;
    logic [4:0]  w_idx;
    logic [3:0]  w_off;
    logic signed [31:0] w_t0, w_t1;
    logic signed [36:0] w_prod;
    logic [36:0] w_pm;
    logic [55:0] w_stp;
    logic signed [33:0] w_val;
    logic signed [33:0] w_dampsum;
    logic signed [34:0] w_tsum;
    logic signed [32:0] w_nr;
    logic signed [32:0] w_na;
    logic signed [33:0] w_w4;
    logic [25:0] w_dtry;
    logic [9:0]  w_mt;
    logic [31:0] w_absang;

    always_comb begin
        // heading minus degrees; degrees enter as their residue mod 360
        w_hd = 12'(r_water_heading);
        w_md = 12'(r_dmod);
        w_rel0 = r_angle[31] ? w_hd + w_md : w_hd - w_md;
        if (w_rel0 < 12'sd0) w_rel0 = w_rel0 + 12'sd360;
        if (w_rel0 < 12'sd0) w_rel0 = w_rel0 + 12'sd360;
        if (w_rel0 < 12'sd0) w_rel0 = w_rel0 + 12'sd360;
        if (w_rel0 >= 12'sd360) w_rel0 = w_rel0 - 12'sd360;
        if (w_rel0 >= 12'sd360) w_rel0 = w_rel0 - 12'sd360;
        w_rel = w_rel0[8:0];
        w_idxp = 22'(r_rel) * Recip15Idx;
        w_idx = w_idxp[20:16];
        if (w_idx > 5'(TablePoints - 2)) w_idx = 5'(TablePoints - 2);
        w_off = 4'(r_rel - 9'(w_idx) * 9'd15);
        w_t0 = torque_tab(r_widx);
        w_t1 = torque_tab(r_widx + 5'd1);
        w_prod = 37'(signed'({1'b0, r_woff})) * (37'(w_t1) - 37'(w_t0));
        w_pm = w_prod[36] ? 37'(-w_prod) : 37'(w_prod);
        w_stp = 56'(r_wy) * Recip15Step;
        w_val = 34'(r_wt0) + (r_wneg ? -34'(r_wst) : 34'(r_wst));
        w_dampsum = 34'(r_dsq) - 34'(m_p);
        w_tsum = 35'(r_damp) + 35'(r_fl) + 35'(r_wt);
        w_nr = 33'(r_rate) + 33'(d_q);
        w_na = 33'(r_angle) + 33'(m_p);
        w_w4 = 34'(m_p) * 34'sd4;
        w_dtry = {r_drem, r_dnum[46]} - {1'b0, DegDen};
        w_mt = {r_dmod, ~w_dtry[25]};
        w_absang = r_angle[31] ? 32'(-r_angle) : 32'(r_angle);
    end

    function automatic logic signed [31:0] sat34(input logic signed [34:0] v);
        if (v > 35'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -35'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction
    function automatic logic ovf34(input logic signed [34:0] v);
        return (v > 35'sh7FFFFFFF) || (v < -35'sh80000000);
    endfunction

    logic signed [31:0] w_dsat;

    always_comb begin
        w_dsat = sat34(35'(w_dampsum));
    end

    always_comb begin
        m_start = 1'b0; m_shift = 1'b1; m_a = '0; m_b = '0;
        case (r_state)
            S_M_ANG:  begin m_start = 1'b1; m_a = {1'b0, r_sample_time}; m_b = r_rate; end
            S_M_RR:   begin m_start = 1'b1; m_a = r_rate; m_b = r_rate; end
            S_M_DSQ:  begin m_start = 1'b1; m_a = KDampSq; m_b = r_rr; end
            S_M_DLIN: begin m_start = 1'b1; m_a = KDampLin; m_b = r_rate; end
            S_M_FL:   begin m_start = 1'b1; m_a = r_force; m_b = r_lever_arm; end
            S_M_SQ:   begin m_start = 1'b1; m_a = r_water_speed; m_b = r_water_speed; end
            S_M_WV:   begin m_start = 1'b1; m_a = r_wval; m_b = r_sq; end
            default:  ;
        endcase
        d_start = (r_state == S_D_START);
        d_num = 64'(r_torque) * 64'(signed'({1'b0, r_sample_time}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= 1'b0;
            r_sample_time <= SampleTimeRst; r_inertia <= InertiaRst;
            r_lever_arm <= LeverArmRst; r_water_speed <= '0; r_water_heading <= '0;
            r_angle <= '0; r_rate <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAMPLE_TIME:   r_sample_time <= i_cfg_data[30:0];
                    CFG_INERTIA:       r_inertia <= i_cfg_data[30:0];
                    CFG_LEVER_ARM:     r_lever_arm <= i_cfg_data;
                    CFG_WATER_SPEED:   r_water_speed <= i_cfg_data;
                    CFG_WATER_HEADING: r_water_heading <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (r_valid && !i_stall) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && !r_valid) begin
                    r_force <= i_drive_force; r_sat <= 1'b0; r_state <= S_M_ANG;
                end
                S_M_ANG: r_state <= S_W_ANG;
                S_W_ANG: if (m_done) begin
                    r_sat <= r_sat | m_sat | ovf34(35'(w_na));
                    r_new_angle <= sat34(35'(w_na));
                    r_state <= S_M_RR;
                end
                S_M_RR: r_state <= S_W_RR;
                S_W_RR: if (m_done) begin
                    r_sat <= r_sat | m_sat; r_rr <= m_p; r_state <= S_M_DSQ;
                end
                S_M_DSQ: r_state <= S_W_DSQ;
                S_W_DSQ: if (m_done) begin
                    r_sat <= r_sat | m_sat; r_dsq <= m_p; r_state <= S_M_DLIN;
                end
                S_M_DLIN: r_state <= S_W_DLIN;
                S_W_DLIN: if (m_done) begin
                    // negation of a saturated min clips once more
                    r_sat <= r_sat | m_sat | ovf34(35'(w_dampsum))
                             | ((r_rate > 0) && (w_dsat == 32'sh80000000));
                    if (r_rate > 0)
                        r_damp <= (w_dsat == 32'sh80000000) ? 34'sh7FFFFFFF
                                                            : -34'(w_dsat);
                    else
                        r_damp <= 34'(w_dsat);
                    r_state <= S_M_FL;
                end
                S_M_FL: r_state <= S_W_FL;
                S_W_FL: if (m_done) begin
                    r_sat <= r_sat | m_sat; r_fl <= m_p;
                    r_dnum <= 47'(w_absang) * 47'd18000;
                    r_drem <= '0; r_dmod <= '0; r_dcnt <= '0;
                    r_state <= S_DEG;
                end
                S_DEG: begin
                    r_dnum <= {r_dnum[45:0], 1'b0};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (!w_dtry[25]) begin
                        r_drem <= w_dtry[24:0];
                    end else begin
                        r_drem <= {r_drem[23:0], r_dnum[46]};
                    end
                    r_dmod <= (w_mt >= 10'd360) ? 9'(w_mt - 10'd360) : w_mt[8:0];
                    if (r_dcnt == 6'd46) r_state <= S_WREL;
                end
                S_WREL: begin
                    r_rel <= w_rel; r_state <= S_WIDX;
                end
                S_WIDX: begin
                    r_widx <= w_idx; r_woff <= w_off; r_state <= S_WPROD;
                end
                S_WPROD: begin
                    r_wt0 <= w_t0; r_wneg <= w_prod[36];
                    r_wy <= 28'(w_pm + 37'd7);
                    r_state <= S_WSTEP;
                end
                S_WSTEP: begin
                    r_wst <= w_stp[54:31]; r_state <= S_M_SQ;
                end
                S_M_SQ: r_state <= S_W_SQ;
                S_W_SQ: if (m_done) begin
                    r_sat <= r_sat | m_sat; r_sq <= m_p;
                    r_wval <= 32'(w_val);
                    r_state <= S_M_WV;
                end
                S_M_WV: r_state <= S_W_WV;
                S_W_WV: if (m_done) begin
                    r_sat <= r_sat | m_sat | ovf34(35'(w_w4));
                    r_wt <= sat34(35'(w_w4));
                    r_state <= S_TRQ;
                end
                S_TRQ: begin
                    r_sat <= r_sat | ovf34(w_tsum);
                    r_torque <= sat34(w_tsum);
                    r_state <= S_D_START;
                end
                S_D_START: r_state <= S_D_WAIT;
                S_D_WAIT: if (d_done) r_state <= S_OUT;
                S_OUT: begin
                    r_out_angle <= r_new_angle;
                    r_out_rate  <= sat34(35'(w_nr));
                    r_out_sat   <= r_sat | d_sat | ovf34(35'(w_nr));
                    r_angle <= r_new_angle; r_rate <= sat34(35'(w_nr));
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE) || r_valid;
    assign o_valid = r_valid;
    assign o_new_angle = r_out_angle;
    assign o_new_rate  = r_out_rate;
    assign o_saturated = r_out_sat;
endmodule

[verif/tb_top.sv]
// Self-checking testbench for rudder_plant_euler_step: drives random and directed forces,
// steps a scoreboard model per transfer and compares each result. Depends on rpe_pkg.
`timescale 1ns / 1ps

class euler_scoreboard;
    localparam longint ONE = 65536;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    longint step_time, inertia_q, lever, w_speed, w_heading;
    int     angle_q, rate_q, angle_prev, rate_prev;
    bit     clipped;
    int     errors;
    int     tab [25] = '{0, -871629, -6488064, -9456845, -12301107,
                         -7864320, -5328077, -2129920, 2215117, 1251738,
                         583270, -471859, 0, -471859, 583270,
                         1251738, 2215117, -2129920, -5328077, -7864320,
                         -12301107, -9456845, -6488064, -871629, 0};
    logic [31:0] exp_angle [$];
    logic [31:0] exp_rate [$];
    bit          exp_sat [$];

    function new();
        step_time = 6554;
        inertia_q = 268042240;
        lever     = 201851;
        w_speed   = 0;
        w_heading = 0;
        angle_q = 0; rate_q = 0; angle_prev = 0; rate_prev = 0;
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            rpe_pkg::CFG_SAMPLE_TIME:   step_time = longint'(data[30:0]);
            rpe_pkg::CFG_INERTIA:       inertia_q = longint'(data[30:0]);
            rpe_pkg::CFG_LEVER_ARM:     lever = longint'(signed'(data));
            rpe_pkg::CFG_WATER_SPEED:   w_speed = longint'(signed'(data));
            rpe_pkg::CFG_WATER_HEADING: w_heading = longint'(signed'(data[9:0]));
            default: ;
        endcase
    endfunction

    function longint clip32(longint v);
        if (v > S32_MAX) begin
            clipped = 1;
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            clipped = 1;
            return S32_MIN;
        end
        return v;
    endfunction

    // round half away from zero, den > 0
    function longint div_round(longint num, longint den);
        longint m;
        longint q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function longint qmul(longint a, longint b);
        return clip32(div_round(a * b, ONE));
    endfunction

    function longint water_term();
        longint deg, rel, idx, off, val, sq, w;
        deg = (longint'(angle_q) * 18000) / (314 * ONE);
        rel = (w_heading - deg) % 360;
        if (rel < 0) rel += 360;
        idx = rel / 15;
        off = rel % 15;
        if (idx > 23) idx = 23;
        val = longint'(tab[idx]) + div_round(off * (longint'(tab[idx+1]) - tab[idx]), 15);
        sq = qmul(w_speed, w_speed);
        w = qmul(val, sq);
        return clip32(w * 4);
    endfunction

    function void note_drive(logic signed [31:0] force_in);
        longint r, den, a_new, damp, wt, trq, dlt, r_new;
        r = rate_q;
        den = (inertia_q > 0) ? inertia_q : 1;
        clipped = 0;
        a_new = clip32(longint'(angle_q) + qmul(step_time, r));
        damp = clip32(qmul(279511040, qmul(r, r)) - qmul(865075, r));
        if (r > 0) damp = clip32(-damp);
        wt = water_term();
        trq = clip32(damp + qmul(longint'(force_in), lever) + wt);
        dlt = clip32(div_round(trq * step_time, den));
        r_new = clip32(r + dlt);
        angle_prev = angle_q;
        rate_prev = rate_q;
        angle_q = int'(a_new);
        rate_q = int'(r_new);
        exp_angle.push_back(a_new[31:0]);
        exp_rate.push_back(r_new[31:0]);
        exp_sat.push_back(clipped);
    endfunction

    function void check_result(logic [31:0] a, logic [31:0] r, logic s);
        logic [31:0] ea, er;
        bit es;
        if (exp_angle.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
            return;
        end
        ea = exp_angle.pop_front();
        er = exp_rate.pop_front();
        es = exp_sat.pop_front();
        if (a !== ea) begin
            $error("new_angle: expected %h, got %h", ea, a);
            errors++;
        end
        if (r !== er) begin
            $error("new_rate: expected %h, got %h", er, r);
            errors++;
        end
        if (s !== es) begin
            $error("saturated: expected %b, got %b", es, s);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import rpe_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [2:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_valid = 0;
    logic               o_stall;
    logic signed [31:0] i_drive_force = '0;
    logic               o_valid;
    logic               i_stall = 1;
    logic signed [31:0] o_new_angle;
    logic signed [31:0] o_new_rate;
    logic               o_saturated;

    euler_scoreboard sb = new();
    bit idle_on = 1;
    bit long_hold = 0;

    rudder_plant_euler_step i_dut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_new_angle, o_new_rate, o_saturated);
    end

    // receiver: random stall before each transfer while idle_on is set, one long hold on request
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = idle_on ? $urandom_range(0, 6) : 0;
            if (long_hold) begin
                n = 2000;
                long_hold = 0;
            end
            if (n > 0) begin
                i_stall <= 1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic drive(logic signed [31:0] f);
        int gap;
        i_valid <= 1;
        i_drive_force <= f;
        do @(posedge i_clk); while (o_stall);
        sb.note_drive(f);
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 0;
        while (sb.exp_angle.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (500) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic write_all(logic [31:0] st, logic [31:0] in, logic [31:0] la,
                             logic [31:0] ws, logic [31:0] wh);
        write_reg(CFG_SAMPLE_TIME, st);
        write_reg(CFG_INERTIA, in);
        write_reg(CFG_LEVER_ARM, la);
        write_reg(CFG_WATER_SPEED, ws);
        write_reg(CFG_WATER_HEADING, wh);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic random_items(int count);
        logic signed [31:0] f;
        for (int k = 0; k < count; k++) begin
            if (k % 32 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 6)
                f = $signed($urandom_range(0, 262144)) - 131072;
            else
                f = $urandom;
            drive(f);
        end
    endtask

    initial begin
        logic signed [31:0] corner [10] = '{0, 1, -1, 32'h7FFFFFFF, 32'h80000000,
                                            65536, -65536, 32'h55555555, 32'hAAAAAAAA, 7};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // defaults from reset
        foreach (corner[k]) drive(corner[k]);
        drain();

        // water flow on, moderate step; long output hold mid-phase
        write_all(6554, 268042240, 201851, 131072, 90);
        for (int k = 0; k < 6; k++) drive(32'sd65536 * k);
        long_hold = 1;
        random_items(80);
        drain();

        // extremes: largest step, zero inertia, min lever, max speed
        write_all(32'hFFFFFFFF, 0, 32'h80000000, 32'h7FFFFFFF, -359);
        foreach (corner[k]) drive(corner[k]);
        random_items(40);
        drain();

        // zero step, max inertia, max lever, min speed
        write_all(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 359);
        random_items(40);
        drain();

        // smallest nonzero inertia, out-of-range heading, ignored index
        write_all(65536, 1, 65536, 65536, 32'h000001FF);
        write_reg(3'd5, $urandom);
        write_reg(3'd7, $urandom);
        i_cfg_we <= 0;
        @(posedge i_clk);
        random_items(40);
        drain();

        // random settings, mostly physical
        for (int p = 0; p < 5; p++) begin
            write_all($urandom_range(100, 20000), $urandom_range(65536, 32'h7FFFFFFF),
                      $signed($urandom_range(0, 800000)) - 400000,
                      $signed($urandom_range(0, 400000)) - 200000, $urandom);
            random_items(60);
            drain();
        end
        write_all($urandom, $urandom, $urandom, $urandom, $urandom);
        random_items(40);
        drain();

        if (sb.errors == 0 && sb.exp_angle.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
